// ----- rtl/blmdh_pkg.sv -----
// ----------------------------------------------------------------------------
// blmdh_pkg: shared definitions for the double-hashing Bloom filter
// Register indexes, request codes, port widths and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package blmdh_pkg;

  // Parameter defaults for the top level.
  localparam int DEF_MAX_BITS   = 65536;
  localparam int DEF_MAX_PROBES = 16;

  // Field and register widths.
  localparam int HASH_W        = 64;
  localparam int HALF_W        = 32;
  localparam int DIVIDEND_W    = 31;
  localparam int FILTER_BITS_W = 17;
  localparam int PROBE_COUNT_W = 5;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 17;

  // Register reset values.
  localparam logic [FILTER_BITS_W-1:0] FILTER_BITS_RST = 17'd65536;
  localparam logic [PROBE_COUNT_W-1:0] PROBE_COUNT_RST = 5'd3;

  // Smallest bit count in use.
  localparam int MIN_BITS = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_BITS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROBE_COUNT = 8'd1;

  // Request codes.
  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_TEST = 1'b1;

endpackage : blmdh_pkg

`default_nettype wire

// ----- rtl/blmdh_mod_unit.sv -----
// ----------------------------------------------------------------------------
// blmdh_mod_unit: iterative remainder unit
// Restoring division, one dividend bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
`default_nettype none

module blmdh_mod_unit #(
  parameter int DIV_W = 17,
  parameter int REM_W = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [blmdh_pkg::DIVIDEND_W-1:0] dividend,
  input  wire logic [DIV_W-1:0]                divisor,
  output logic                                 done,
  output logic [REM_W-1:0]                     remainder
);
  import blmdh_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DIVIDEND_W - 1);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIVIDEND_W-1:0] dvd_r;
  logic [REM_W-1:0]      rem_r;
  logic [DIV_W-1:0]      div_r;

  logic [REM_W:0]   trial;
  logic [REM_W:0]   div_ext;
  logic [REM_W:0]   diff;
  logic [REM_W-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, dvd_r[DIVIDEND_W-1]};
    div_ext = (REM_W+1)'(div_r);
    diff    = trial - div_ext;
    if (trial >= div_ext) begin
      rem_nxt = diff[REM_W-1:0];
    end else begin
      rem_nxt = trial[REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == LAST);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == LAST)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      cnt_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DIVIDEND_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule : blmdh_mod_unit

`default_nettype wire

// ----- rtl/blmdh_store.sv -----
// ----------------------------------------------------------------------------
// blmdh_store: byte-wide bit store of the filter
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module blmdh_store #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic [7:0]         rd_data
);

  logic [7:0] mem [0:DEPTH-1];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule : blmdh_store

`default_nettype wire

// ----- rtl/bloom_filter_double_hash.sv -----
// A request word is accepted only in the idle state, so one word is worked on at a time;
// a test that meets a clear bit stops early. The remainder unit, which takes one dividend
// bit a cycle, sets the pace of each probe. After reset a clearing pass writes every store
// byte to zero, one byte per cycle (8192 bytes by default); no word is accepted meanwhile.
// Registers reset to 65536 bits, 3 probes, and take writes any time.
// ----------------------------------------------------------------------------
// bloom_filter_double_hash: Bloom filter with double-hash probing
// Each probe position is (h1 + i*h2), folded to 31 bits, modulo the bit count.
// ----------------------------------------------------------------------------
`default_nettype none

module bloom_filter_double_hash #(
  parameter int MAX_BITS   = blmdh_pkg::DEF_MAX_BITS,
  parameter int MAX_PROBES = blmdh_pkg::DEF_MAX_PROBES
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Request words.
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_req_type,
  input  wire logic [blmdh_pkg::HASH_W-1:0]      in_hash_value,
  // Result words, one per test.
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_maybe_present,
  // Configuration writes.
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [blmdh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [blmdh_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import blmdh_pkg::*;

  // Widths that follow from the capacity and probe limit.
  localparam int STORE_BYTES = (MAX_BITS + 7) / 8;
  localparam int PW          = $clog2(MAX_BITS);      // bit position
  localparam int NBW         = $clog2(MAX_BITS + 1);  // active bit count
  localparam int AW          = PW - 3;                // byte address
  localparam int IW          = $clog2(MAX_PROBES + 2); // probe index

  // Sequencer states. NEXT decides whether another probe follows, MOD waits
  // for the remainder unit, CHK sees the byte read back from the store.
  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_NEXT   = 6'b000100,
    ST_MOD    = 6'b001000,
    ST_CHK    = 6'b010000,
    ST_RESULT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [FILTER_BITS_W-1:0] filter_bits_r;
  logic [PROBE_COUNT_W-1:0] probe_count_r;

  // Work registers for the item in flight.
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic              type_r, type_nxt;
  logic [HALF_W-1:0] h2_r, h2_nxt;
  logic [HALF_W-1:0] c_r, c_nxt;
  logic [IW-1:0]     i_r, i_nxt;
  logic [IW-1:0]     k_r, k_nxt;
  logic [NBW-1:0]    nb_r, nb_nxt;
  logic [2:0]        bit_r, bit_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic              present_r, present_nxt;

  // Output register, which frees the sequencer while a result waits.
  logic out_valid_r, out_valid_nxt;
  logic out_present_r, out_present_nxt;

  // Saturated settings, sampled when a word is accepted.
  logic [IW-1:0]  k_sat;
  logic [NBW-1:0] nb_sat;

  // Remainder unit and store hookup.
  logic                  mod_start;
  logic [DIVIDEND_W-1:0] mod_dividend;
  logic                  mod_done;
  logic [PW-1:0]         mod_rem;
  logic [HALF_W-1:0]     c_sum;

  logic          st_wr_en;
  logic [AW-1:0] st_wr_addr;
  logic [7:0]    st_wr_data;
  logic          st_rd_en;
  logic [AW-1:0] st_rd_addr;
  logic [7:0]    st_rd_data;
  logic          in_acc;
  logic          bit_hit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_bits_r <= FILTER_BITS_RST;
      probe_count_r <= PROBE_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FILTER_BITS: filter_bits_r <= cfg_data[FILTER_BITS_W-1:0];
        REG_PROBE_COUNT: probe_count_r <= cfg_data[PROBE_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the bit count to [8, MAX_BITS] and the probe count to MAX_PROBES.
  always_comb begin
    if (32'(filter_bits_r) > 32'(MAX_BITS)) begin
      nb_sat = NBW'(MAX_BITS);
    end else if (32'(filter_bits_r) < 32'(MIN_BITS)) begin
      nb_sat = NBW'(MIN_BITS);
    end else begin
      nb_sat = NBW'(filter_bits_r);
    end
    if (32'(probe_count_r) > 32'(MAX_PROBES)) begin
      k_sat = IW'(MAX_PROBES);
    end else begin
      k_sat = IW'(probe_count_r);
    end
  end

  // The next probe value is kept as a running sum, so i*h2 needs no multiplier.
  // A value with its sign bit set is inverted, which leaves 31 bits.
  always_comb begin
    c_sum = c_r + h2_r;
    if (c_sum[HALF_W-1]) begin
      mod_dividend = ~c_sum[DIVIDEND_W-1:0];
    end else begin
      mod_dividend = c_sum[DIVIDEND_W-1:0];
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign bit_hit  = st_rd_data[bit_r];

  always_comb begin
    state_nxt       = state_r;
    clr_cnt_nxt     = clr_cnt_r;
    type_nxt        = type_r;
    h2_nxt          = h2_r;
    c_nxt           = c_r;
    i_nxt           = i_r;
    k_nxt           = k_r;
    nb_nxt          = nb_r;
    bit_nxt         = bit_r;
    addr_nxt        = addr_r;
    present_nxt     = present_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_present_nxt = out_present_r;
    mod_start       = 1'b0;
    st_wr_en        = 1'b0;
    st_wr_addr      = addr_r;
    st_wr_data      = st_rd_data | (8'd1 << bit_r);
    st_rd_en        = 1'b0;
    st_rd_addr      = mod_rem[PW-1:3];

    case (state_r)
      ST_CLEAR: begin
        st_wr_en    = 1'b1;
        st_wr_addr  = clr_cnt_r;
        st_wr_data  = 8'd0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(STORE_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          type_nxt    = in_req_type;
          c_nxt       = in_hash_value[HALF_W-1:0];
          h2_nxt      = in_hash_value[HASH_W-1:HALF_W];
          i_nxt       = IW'(1);
          k_nxt       = k_sat;
          nb_nxt      = nb_sat;
          present_nxt = 1'b1;
          state_nxt   = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (i_r > k_r) begin
          if (type_r == REQ_TEST) begin
            state_nxt = ST_RESULT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          mod_start = 1'b1;
          c_nxt     = c_sum;
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          st_rd_en  = 1'b1;
          addr_nxt  = mod_rem[PW-1:3];
          bit_nxt   = mod_rem[2:0];
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        i_nxt = i_r + IW'(1);
        if (type_r == REQ_ADD) begin
          st_wr_en  = 1'b1;
          state_nxt = ST_NEXT;
        end else if (!bit_hit) begin
          // First clear bit ends the test: definitely absent.
          present_nxt = 1'b0;
          state_nxt   = ST_RESULT;
        end else begin
          state_nxt = ST_NEXT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_present_nxt = present_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    type_r        <= type_nxt;
    h2_r          <= h2_nxt;
    c_r           <= c_nxt;
    i_r           <= i_nxt;
    k_r           <= k_nxt;
    nb_r          <= nb_nxt;
    bit_r         <= bit_nxt;
    addr_r        <= addr_nxt;
    present_r     <= present_nxt;
    out_present_r <= out_present_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_maybe_present = out_present_r;

  blmdh_mod_unit #(
    .DIV_W (NBW),
    .REM_W (PW)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (mod_dividend),
    .divisor   (nb_r),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  blmdh_store #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  // The remainder unit only reports back while the sequencer waits for it.
  a_mod_done_in_mod : assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == ST_MOD))
    else $error("remainder unit finished outside the wait state");

  // A computed position always lies below the active bit count.
  a_pos_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (NBW'(mod_rem) < nb_r))
    else $error("probe position not below the bit count");

  // The probe index never runs past one beyond the probe count.
  a_probe_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NEXT || state_r == ST_MOD || state_r == ST_CHK) |->
      (i_r <= k_r + IW'(1)))
    else $error("probe index overran the probe count");

  // A new result word only ever follows a test.
  a_result_from_test : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(type_r == REQ_TEST))
    else $error("result word produced for an add");

  // No word is taken until the clearing pass has finished.
  a_no_accept_in_clear : assert property (@(posedge clk) disable iff (!rst_n)
    st_wr_en && (state_r == ST_CLEAR) |-> !in_ready)
    else $error("word accepted during clearing pass");

endmodule : bloom_filter_double_hash

`default_nettype wire

// ----- sim/tb_bloom_filter_double_hash.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bloom_filter_double_hash: self-checking bench for the double-hash Bloom filter
// Drives add and test words through the filter under several register settings,
// mirrors the bit store in a local model and compares every result word in order.
// ----------------------------------------------------------------------------

module tb_bloom_filter_double_hash;

  import blmdh_pkg::*;

  // Store geometry and timing derived from the default parameters.
  localparam int          STORE_BYTES = (DEF_MAX_BITS + 7) / 8;
  // At most one add can still be in flight after the last result; the settling
  // pause covers two full-length items.
  localparam int          ITEM_CYCLES  = 34 * DEF_MAX_PROBES + 3;
  localparam int          DRAIN_CYCLES = 2 * ITEM_CYCLES + 20;
  // Long receiver hold-off that makes the filter back up into its input.
  localparam int          HOLD_CYCLES  = 3000;
  // Generous ceiling on the whole run, clearing pass included.
  localparam int unsigned LIMIT_CYCLES = 3_000_000;
  // A register index that matches no register; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 8'hff;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic                  req;
    logic [HASH_W-1:0]     hash;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    bit                    typed;
    bit                    typed_val;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_req_type;
  logic [HASH_W-1:0]     in_hash_value;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_maybe_present;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bloom_filter_double_hash uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_hash_value     (in_hash_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_maybe_present (out_maybe_present),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // Local copy of the filter: the bit store (empty after reset) and the two
  // registers as last written.
  bit [7:0]               shadow_store [STORE_BYTES];
  logic [FILTER_BITS_W-1:0] shadow_bits   = FILTER_BITS_RST;
  logic [PROBE_COUNT_W-1:0] shadow_probes = PROBE_COUNT_RST;

  // Answers still owed by the filter, oldest first.
  bit             presence_q [$];
  // Hashes added under the current setting, so tests can hit them.
  logic [HASH_W-1:0] added_keys [$];
  dir_row_t       dir_rows [$];

  int             err_cnt;
  int             words_since_cfg;
  int unsigned    cycle_cnt;
  int             send_idle_pct;
  int             recv_idle_pct;
  int             hold_req;
  bit             want_present;

  // Free-running clock, 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // Watchdog: a run that does not finish in time has hung somewhere.
  initial begin
    wait (cycle_cnt >= LIMIT_CYCLES);
    $display("TEST FAILED");
    $finish;
  end

  // Probe the local filter the way the hardware does. An add sets every probed
  // bit; a test stops at the first clear bit. The bit count is clamped to the
  // range [MIN_BITS, MAX_BITS] and the probe count to MAX_PROBES; a probe
  // count of zero makes no probe at all, so a test then answers present.
  function automatic bit lookup_filter(input logic req, input logic [HASH_W-1:0] hash);
    bit [31:0]   h1;
    bit [31:0]   h2;
    bit [31:0]   c;
    bit [31:0]   pos;
    bit [31:0]   nb;
    int unsigned k;
    bit          hit;
    h1  = hash[HALF_W-1:0];
    h2  = hash[HASH_W-1:HALF_W];
    nb  = 32'(shadow_bits);
    if (nb > DEF_MAX_BITS) nb = DEF_MAX_BITS;
    if (nb < MIN_BITS) nb = MIN_BITS;
    k   = 32'(shadow_probes);
    if (k > DEF_MAX_PROBES) k = DEF_MAX_PROBES;
    hit = 1'b1;
    for (int unsigned i = 1; i <= k; i++) begin
      c = h1 + i * h2;
      // A negative probe is folded back by inverting it, not by negation.
      if (c[31]) c = ~c;
      pos = c % nb;
      if (req == REQ_ADD) begin
        shadow_store[pos >> 3][pos[2:0]] = 1'b1;
      end else if (!shadow_store[pos >> 3][pos[2:0]]) begin
        hit = 1'b0;
        break;
      end
    end
    return hit;
  endfunction

  // Hashes that sit on the corners of the probe arithmetic: zero step,
  // all ones, the sign bit of the upper half, the largest positive lower half.
  function automatic logic [HASH_W-1:0] corner_hash();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return {32'h0, r};
      3: return {r, 32'h0};
      4: return {32'h8000_0000, r};
      default: return {r, 32'h7fff_ffff};
    endcase
  endfunction

  function automatic void row_word(input logic req, input logic [HASH_W-1:0] hash,
                                   input bit typed, input bit typed_val);
    dir_row_t row;
    row.kind      = ROW_WORD;
    row.req       = req;
    row.hash      = hash;
    row.idx       = '0;
    row.data      = '0;
    row.typed     = typed;
    row.typed_val = typed_val;
    dir_rows.push_back(row);
  endfunction

  function automatic void row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    dir_row_t row;
    row.kind      = ROW_CFG;
    row.req       = REQ_ADD;
    row.hash      = '0;
    row.idx       = idx;
    row.data      = data;
    row.typed     = 1'b0;
    row.typed_val = 1'b0;
    dir_rows.push_back(row);
  endfunction

  // Offer one request word, starting and ending at a falling edge. Valid is
  // left high afterwards so back-to-back words never toggle it within a step;
  // it only drops when the sender decides to pause, before a register write and
  // for the final drain. The expected answer is worked out at the edge that accepts the word.
  task automatic send_word(input logic req, input logic [HASH_W-1:0] hash,
                           input bit typed, input bit typed_val);
    bit predicted;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      // Pause lengths vary widely so gaps land on every part of a probe pass.
      repeat ($urandom_range(1, 120)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_hash_value <= hash;
    do @(posedge clk); while (!in_ready);
    predicted = lookup_filter(req, hash);
    if (req == REQ_TEST) presence_q.push_back(typed ? typed_val : predicted);
    words_since_cfg++;
    @(negedge clk);
  endtask

  // Write one register with the filter idle: every answer in, then a pause
  // long enough for any add still being probed to finish.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    while (presence_q.size() != 0) @(negedge clk);
    repeat (words_since_cfg != 0 ? DRAIN_CYCLES : 1) @(negedge clk);
    words_since_cfg = 0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_FILTER_BITS) shadow_bits = data;
    else if (idx == REG_PROBE_COUNT) shadow_probes = data[PROBE_COUNT_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic under one setting. Most words are adds of fresh keys and
  // tests of keys already added, which must come back present; the rest are
  // tests of unseen keys and corner hashes of either kind.
  task automatic run_batch(input int n);
    logic [HASH_W-1:0] key;
    logic [31:0]       r;
    int                pick;
    added_keys.delete();
    repeat (n) begin
      pick = $urandom_range(0, 99);
      r    = $urandom;
      if (pick < 40) begin
        key = {$urandom, $urandom};
        send_word(REQ_ADD, key, 1'b0, 1'b0);
        added_keys.push_back(key);
        if (added_keys.size() > 64) void'(added_keys.pop_front());
      end else if (pick < 75 && added_keys.size() != 0) begin
        send_word(REQ_TEST, added_keys[$urandom_range(0, added_keys.size() - 1)],
                  1'b0, 1'b0);
      end else if (pick < 90) begin
        send_word(REQ_TEST, {$urandom, $urandom}, 1'b0, 1'b0);
      end else begin
        send_word(r[0], corner_hash(), 1'b0, 1'b0);
      end
    end
  endtask

  // Receiver: per-cycle random stalls, an occasional longer stall, and the
  // long hold-off requested by the stimulus, counted down here.
  initial begin : receiver
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end else if (hold_left == 0 && recv_idle_pct > 0 && $urandom_range(0, 199) == 0) begin
        hold_left = $urandom_range(1, 200);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Result checker: every accepted result word is matched against the
  // oldest answer still owed.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (presence_q.size() == 0) begin
        $display("%0t: result word with none expected, expected none, actual %0b",
                 $time, out_maybe_present);
        err_cnt++;
      end else begin
        want_present = presence_q.pop_front();
        if (out_maybe_present !== want_present) begin
          $display("%0t: maybe_present mismatch, expected %0b, actual %0b",
                   $time, want_present, out_maybe_present);
          err_cnt++;
        end
      end
    end
  end

  // Main sequence: reset, the directed table, three phases of random
  // traffic with different idling, then the final drain and verdict.
  initial begin : stimulus
    logic [31:0]              rnd;
    logic [CFG_DATA_W-1:0]    bits_val;
    logic [PROBE_COUNT_W-1:0] probes_val;
    int                       n_items;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_req_type     = REQ_ADD;
    in_hash_value   = '0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    err_cnt         = 0;
    words_since_cfg = 0;
    hold_req        = 0;
    send_idle_pct   = 15;
    recv_idle_pct   = 56;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. The filter starts empty, so the first two tests must
    // miss; a probe count of zero makes any test answer present.
    row_word(REQ_TEST, 64'h0, 1'b1, 1'b0);
    row_word(REQ_TEST, 64'hffff_ffff_ffff_ffff, 1'b1, 1'b0);
    row_word(REQ_ADD,  64'h0, 1'b0, 1'b0);
    row_word(REQ_TEST, 64'h0, 1'b0, 1'b0);
    row_word(REQ_ADD,  64'hffff_ffff_ffff_ffff, 1'b0, 1'b0);
    row_word(REQ_TEST, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b0);
    row_word(REQ_ADD,  64'h7fff_ffff_7fff_ffff, 1'b0, 1'b0);
    row_word(REQ_TEST, 64'h7fff_ffff_7fff_ffff, 1'b0, 1'b0);
    row_word(REQ_TEST, 64'h8000_0000_8000_0000, 1'b0, 1'b0);
    // Bit count above capacity saturates.
    row_cfg(REG_FILTER_BITS, 17'h1ffff);
    row_word(REQ_TEST, 64'h7fff_ffff_7fff_ffff, 1'b0, 1'b0);
    // No probes: the add changes nothing, the test answers present.
    row_cfg(REG_PROBE_COUNT, 17'd0);
    row_word(REQ_ADD,  64'h0123_4567_89ab_cdef, 1'b0, 1'b0);
    row_word(REQ_TEST, 64'h0123_4567_89ab_cdef, 1'b1, 1'b1);
    // Probe count above the maximum saturates.
    row_cfg(REG_PROBE_COUNT, 17'd31);
    row_word(REQ_ADD,  64'h0000_0001_0000_0000, 1'b0, 1'b0);
    row_word(REQ_TEST, 64'h0000_0001_0000_0000, 1'b0, 1'b0);
    // Bit count of zero is taken as the minimum.
    row_cfg(REG_FILTER_BITS, 17'd0);
    row_word(REQ_ADD,  64'h0000_0000_0000_0005, 1'b0, 1'b0);
    row_word(REQ_TEST, 64'hfedc_ba98_7654_3210, 1'b0, 1'b0);
    // Bit count that is not a multiple of eight.
    row_cfg(REG_FILTER_BITS, 17'd100);
    row_cfg(REG_PROBE_COUNT, 17'd1);
    row_word(REQ_ADD,  64'hffff_ffff_0000_0063, 1'b0, 1'b0);
    row_word(REQ_TEST, 64'hffff_ffff_0000_0063, 1'b0, 1'b0);
    // A write to an unknown index must leave both registers alone.
    row_cfg(REG_NONE, 17'h1ffff);
    row_word(REQ_TEST, 64'h0000_0000_0000_0001, 1'b0, 1'b0);
    // Bit count below eight but not zero.
    row_cfg(REG_FILTER_BITS, 17'd5);
    row_word(REQ_TEST, 64'h0000_0000_0000_002a, 1'b0, 1'b0);

    foreach (dir_rows[j]) begin
      if (dir_rows[j].kind == ROW_CFG) begin
        write_reg(dir_rows[j].idx, dir_rows[j].data);
      end else begin
        send_word(dir_rows[j].req, dir_rows[j].hash, dir_rows[j].typed,
                  dir_rows[j].typed_val);
      end
    end

    // Random part. Phase 0: sender idles lightly, receiver heavily; phase 1
    // the other way round; phase 2 without idling, opened by a long hold-off
    // on the result side so the filter stalls its input.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct = 56;
        end
        1: begin
          send_idle_pct = 56;
          recv_idle_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int b = 0; b < 5; b++) begin
        rnd = $urandom;
        // Small bit counts fill up quickly and give many false positives;
        // the largest ones mostly give clean misses.
        case ($urandom_range(0, 7))
          0: bits_val = 17'd8;
          1: bits_val = 17'd64;
          2: bits_val = 17'd100;
          3: bits_val = 17'd1000;
          4: bits_val = 17'd4096;
          5: bits_val = 17'd65536;
          6: bits_val = 17'h1ffff;
          default: bits_val = rnd[CFG_DATA_W-1:0];
        endcase
        // Few probes most of the time, since each probe costs a division.
        case ($urandom_range(0, 9))
          7: probes_val = 5'd16;
          8: probes_val = 5'd17 + rnd[20:17] % 15;
          9: probes_val = 5'd0;
          default: probes_val = 5'd1 + rnd[22:21];
        endcase
        write_reg(REG_FILTER_BITS, bits_val);
        write_reg(REG_PROBE_COUNT, {{(CFG_DATA_W-PROBE_COUNT_W){1'b0}}, probes_val});
        if (rnd[31:29] == 3'd0) begin
          write_reg(8'd2 + rnd[28:23] * 8'd4, rnd[CFG_DATA_W-1:0]);
        end
        n_items = (probes_val >= 5'd8) ? 40 : 160;
        if (ph == 2 && b == 0) hold_req++;
        run_batch(n_items);
      end
    end

    // Drain: every answer in, then room for any trailing add to complete.
    in_valid <= 1'b0;
    while (presence_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_cnt == 0 && presence_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
